// ----- sv/sliding_median_filter_top_assert.svh -----
// Assertion macros for the sliding median filter checker.
// Each macro expands to one labelled concurrent assertion on the rising edge of i_clk.
`ifndef SLIDING_MEDIAN_FILTER_TOP_ASSERT_SVH
`define SLIDING_MEDIAN_FILTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg
// Types and constants shared by the sliding median filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    // Register index, taken from paddr[2]
    localparam logic REG_HALF_WIDTH = 1'b0;
    localparam int HALF_W = 3;
    localparam logic [HALF_W-1:0] HALF_RESET = 3'd1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RANK,
        S_PICK
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic shift_in;
        logic load;
        logic rank_step;
        logic pick;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic last;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/smf_ctrl.sv -----
// ----------------------------------------------------------------------------
// smf_ctrl
// Controller: sequences sample intake, ranking passes and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_ctrl
    import smf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.shift_in = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_status.full ? S_RANK : S_IDLE;
            end
            S_RANK: begin
                o_cmd.rank_step = 1'b1;
                if (i_status.last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.pick = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on a new result, drop after transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.pick) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- sv/smf_dpath.sv -----
// ----------------------------------------------------------------------------
// smf_dpath
// Datapath: sample shift line, rank lanes and median output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_dpath
    import smf_pkg::*;
#(
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_start_req,
    input  wire logic [HALF_W-1:0]      i_half_width,
    output t_dp_status                  o_status,
    output logic [SAMPLE_BITS-1:0]      o_median
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Tap 0 is the newest sample
    logic [SAMPLE_BITS-1:0] r_tap  [DEPTH];
    logic [SAMPLE_BITS-1:0] r_copy [DEPTH];
    logic [CNT_W-1:0]       r_rank [DEPTH];
    logic [CNT_W-1:0]       r_fill;
    logic [CNT_W-1:0]       r_k;
    logic [SAMPLE_BITS-1:0] r_median;

    logic [CNT_W-1:0]       half;
    logic [CNT_W-1:0]       win_len;
    logic [SAMPLE_BITS-1:0] pick_val;

    // Saturate the half width and derive the window length
    always_comb begin
        if (int'(i_half_width) > MAX_HALF) begin
            half = CNT_W'(MAX_HALF);
        end else begin
            half = CNT_W'(i_half_width);
        end
        win_len = (half << 1) + CNT_W'(1);
    end

    // Advance the shift line on each new sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_in) begin
            r_tap[0] <= i_sample;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    // Fill count: restart on a start flag, saturate at the full depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.shift_in) begin
            if (i_start_req) begin
                r_fill <= CNT_W'(1);
            end else if (r_fill < CNT_W'(DEPTH)) begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

    // Pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.load) begin
            r_k <= '0;
        end else if (i_cmd.rank_step) begin
            r_k <= r_k + CNT_W'(1);
        end
    end

    // Copy line: load from the taps, then shift one entry per pass towards entry 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_copy[i] <= r_tap[i];
            end
        end else if (i_cmd.rank_step) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_copy[i] <= r_copy[i+1];
            end
        end
    end

    // Rank lanes: each lane counts window entries that sort ahead of its own,
    // ties broken by age so every rank is unique
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DEPTH; j++) begin
            if (i_cmd.load) begin
                r_rank[j] <= '0;
            end else if (i_cmd.rank_step) begin
                if ((r_copy[0] < r_tap[j]) ||
                    ((r_copy[0] == r_tap[j]) && (r_k < CNT_W'(j)))) begin
                    r_rank[j] <= r_rank[j] + CNT_W'(1);
                end
            end
        end
    end

    // Select the lane whose rank is the middle one
    always_comb begin
        pick_val = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if ((CNT_W'(j) < win_len) && (r_rank[j] == half)) begin
                pick_val = pick_val | r_tap[j];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_median <= pick_val;
        end
    end

    assign o_status.full = (r_fill >= win_len);
    assign o_status.last = (r_k == win_len - CNT_W'(1));
    assign o_median      = r_median;

endmodule

`default_nettype wire

// ----- sv/sliding_median_filter_top.sv -----
// ----------------------------------------------------------------------------
// sliding_median_filter_top
// Sliding-window median over the newest 2*half_width+1 ADC samples.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  input    | i_in_valid, o_in_stall, i_sample, i_start_req | in
//  output   | o_out_valid, i_out_stall, o_median        | out
//  config   | psel, penable, pwrite, paddr, pwdata,     | APB
//           | prdata, pready (half_width at address 0)  |
//
//  An item with a full window goes from its transfer through load, one rank pass
//  per window entry (n = 2*half_width+1 passes) through a shared broadcast compare
//  and pick before the next transfer; items that give no result skip rank and pick.
//  Reset is synchronous and active low; it clears the fill count and control.
//  A stalled result is held in the output register; the next input is taken
//  meanwhile, and its result waits in the pick state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_filter_top
    import smf_pkg::*;
#(
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Sample input
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_start_req,
    // Median output
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0]      o_median,
    // Configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]       prdata,
    output logic                        pready
);

    logic [HALF_W-1:0] r_half_width;
    t_dp_cmd           cmd;
    t_dp_status        status;

    // Configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HALF_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_HALF_WIDTH)) begin
            r_half_width <= pwdata[HALF_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HALF_WIDTH) begin
            prdata = {{(CFG_DATA_W-HALF_W){1'b0}}, r_half_width};
        end
    end

    assign pready = 1'b1;

    smf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    smf_dpath #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample     (i_sample),
        .i_start_req  (i_start_req),
        .i_half_width (r_half_width),
        .o_status     (status),
        .o_median     (o_median)
    );

endmodule

`default_nettype wire

// ----- sv/smf_chk.sv -----
// ----------------------------------------------------------------------------
// smf_chk
// Port-level checks for the sliding median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_median_filter_top_assert.svh"

module smf_chk #(
    parameter int SAMPLE_BITS = 12
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_stall,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_stall,
    input wire logic [SAMPLE_BITS-1:0] o_median
);

    // A result register held under stall keeps its value
    `SMF_ASSERT_NEXT(a_out_hold, i_rst_n && o_out_valid && i_out_stall, o_out_valid && $stable(o_median), "result changed while stalled")

    // After a transfer in, the input side stalls while the sample is processed
    `SMF_ASSERT_NEXT(a_in_busy, i_rst_n && i_in_valid && !o_in_stall, o_in_stall, "input not stalled after transfer")

    // A result cannot appear in the cycle right after a transfer in
    `SMF_ASSERT_NEXT(a_no_early, i_rst_n && i_in_valid && !o_in_stall, !$rose(o_out_valid), "result too early")

    // Reset leaves no result pending and the input open
    `SMF_ASSERT_NEXT(a_reset, !i_rst_n, !o_out_valid && !o_in_stall, "bad state after reset")

endmodule

bind sliding_median_filter_top smf_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_smf_chk (.*);

`default_nettype wire

// ----- sim/sliding_median_filter_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_median_filter_top_tb
// Self-checking bench for the sliding-window median filter. A scoreboard keeps
// its own sample history and works out the median of the newest window for
// each sample taken while the window is full. Each median that leaves the block
// is compared with the oldest outstanding one. The window size is changed over
// the APB port between phases and read back. Random gaps and stalls are applied
// on both channels.
// ----------------------------------------------------------------------------

module sliding_median_filter_top_tb;
    import smf_pkg::*;

    localparam int MAX_HALF      = 7;
    localparam int SAMPLE_BITS   = 12;
    localparam int DEPTH         = 2 * MAX_HALF + 1;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_SAMPLES = 100;

    localparam logic [CFG_ADDR_W-1:0] ADDR_HALF_WIDTH = {REG_HALF_WIDTH, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE      = {~REG_HALF_WIDTH, 2'b00};

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef enum int {SPREAD, CLUSTER, EXTREME} t_flavour;

    // ------------------------------------------------------------------------
    // Scoreboard: sample history and the medians still owed by the block
    // ------------------------------------------------------------------------
    class median_scoreboard;
        t_sample     history[DEPTH];
        int unsigned held;
        int unsigned next_slot;
        int unsigned half;
        t_sample     expected_medians[$];
        int unsigned mismatches;
        int unsigned medians_checked;

        function new();
            held            = 0;
            next_slot       = 0;
            half            = int'(HALF_RESET);
            mismatches      = 0;
            medians_checked = 0;
        endfunction

        // Sort the newest 2*half+1 samples and take the middle one
        function t_sample median_of_newest();
            t_sample     win[DEPTH];
            t_sample     v;
            int unsigned n;
            int          j;
            n = 2 * half + 1;
            for (int i = 0; i < n; i++) begin
                win[i] = history[(next_slot + 2 * DEPTH - 1 - i) % DEPTH];
            end
            for (int i = 1; i < n; i++) begin
                v = win[i];
                j = i;
                while (j > 0 && win[j-1] > v) begin
                    win[j] = win[j-1];
                    j--;
                end
                win[j] = v;
            end
            return win[half];
        endfunction

        // Store an accepted sample and queue a median once the window is full
        function void note_sample(t_sample s, logic restart);
            if (restart) begin
                held      = 0;
                next_slot = 0;
            end
            history[next_slot] = s;
            next_slot = (next_slot + 1) % DEPTH;
            if (held < DEPTH) begin
                held++;
            end
            if (held >= 2 * half + 1) begin
                expected_medians.insert(expected_medians.size(), median_of_newest());
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_median(t_sample got);
            t_sample want;
            medians_checked++;
            if (expected_medians.size() == 0) begin
                report_mismatch($sformatf("median %0d with none outstanding", got));
            end else begin
                want = expected_medians.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("median %0d, expected %0d", got, want));
                end
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_sample               i_sample;
    logic                  i_start_req;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_sample               o_median;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    median_scoreboard sb;
    logic             steady;
    int unsigned      samples_sent;
    int unsigned      settings_used;

    sliding_median_filter_top #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_start_req (i_start_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_median    (o_median),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up if the run hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stall the result channel at random, except in steady stretches
    always @(posedge i_clk) begin
        i_out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 16);
    end

    // Check every median transfer
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_median(o_median);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one sample, idling first at random, and hold it until the transfer
    task automatic push_sample(input t_sample s, input logic restart);
        while (!steady && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample    <= s;
        i_start_req <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_sample(s, restart);
        samples_sent++;
    endtask

    // Hold off the sender until every owed median is out, then let the block settle
    task automatic wait_for_medians();
        i_in_valid <= 1'b0;
        while (sb.expected_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer; the read data is returned for reads
    task automatic apb_transfer(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data,
                                output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register (upper bits random), then read the half width back
    task automatic write_config(input logic [CFG_ADDR_W-1:0] addr, input int unsigned h);
        logic [CFG_DATA_W-1:0] data;
        logic [CFG_DATA_W-1:0] got;
        data             = $urandom();
        data[HALF_W-1:0] = h[HALF_W-1:0];
        apb_transfer(1'b1, addr, data, got);
        if (addr == ADDR_HALF_WIDTH) begin
            sb.half = h;
            settings_used++;
        end
        apb_transfer(1'b0, ADDR_HALF_WIDTH, '0, got);
        if (got !== CFG_DATA_W'(sb.half)) begin
            sb.report_mismatch($sformatf("half width reads %0d, expected %0d", got, sb.half));
        end
    endtask

    // One stretch of random samples: mostly long signals, with bursts of restarts
    task automatic run_signal_phase(input int unsigned count, input logic fresh);
        t_flavour    flavour;
        int unsigned base;
        int unsigned drain_at;
        int unsigned burst;
        t_sample     s;
        logic        restart;
        flavour  = t_flavour'($urandom_range(0, 2));
        base     = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
        drain_at = $urandom_range(0, count - 1);
        burst    = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0 && $urandom_range(0, 99) < 3) begin
                burst = $urandom_range(2, 8);
            end
            if (burst != 0) begin
                restart = 1'($urandom_range(0, 1));
                burst--;
            end else begin
                restart = (i == 0 && fresh) || ($urandom_range(0, 99) < 2);
            end
            case (flavour)
                SPREAD: begin
                    s = t_sample'($urandom());
                end
                CLUSTER: begin
                    s = t_sample'(base + $urandom_range(0, 15));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: s = '0;
                        1: s = '1;
                        2: s = t_sample'(1 << (SAMPLE_BITS - 1));
                        default: s = t_sample'((1 << (SAMPLE_BITS - 1)) - 1);
                    endcase
                end
            endcase
            push_sample(s, restart);
            if (i == drain_at) begin
                wait_for_medians();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] got;
        int unsigned           h;

        sb            = new();
        steady        = 1'b0;
        samples_sent  = 0;
        settings_used = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_sample      <= '0;
        i_start_req   <= 1'b0;
        i_out_stall   <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value of the half width
        apb_transfer(1'b0, ADDR_HALF_WIDTH, '0, got);
        if (got !== CFG_DATA_W'(HALF_RESET)) begin
            sb.report_mismatch($sformatf("half width after reset reads %0d", got));
        end

        // Three-sample window: extremes, duplicates, alternating bits, restart
        push_sample(12'h000, 1'b1);
        push_sample(12'hFFF, 1'b0);
        push_sample(12'hFFF, 1'b0);
        push_sample(12'h000, 1'b0);
        push_sample(12'h000, 1'b0);
        push_sample(12'h800, 1'b0);
        push_sample(12'h7FF, 1'b0);
        push_sample(12'hAAA, 1'b0);
        push_sample(12'h555, 1'b0);
        push_sample(12'd100, 1'b1);
        push_sample(12'd100, 1'b0);
        push_sample(12'd5,   1'b0);
        wait_for_medians();

        // Single-sample window: a restart yields a median at once
        write_config(ADDR_HALF_WIDTH, 0);
        push_sample(12'd3000, 1'b1);
        push_sample(12'hFFF,  1'b0);
        push_sample(12'h000,  1'b1);
        wait_for_medians();

        // Unused register address must leave the half width alone
        write_config(ADDR_SPARE, 5);

        // Grow to the widest window mid-signal: no median until 15 samples are held
        write_config(ADDR_HALF_WIDTH, MAX_HALF);
        for (int i = 0; i < 14; i++) begin
            push_sample(t_sample'((i * 997) % 1024), 1'b0);
        end
        wait_for_medians();

        // Shrink mid-signal: medians resume straight away
        write_config(ADDR_HALF_WIDTH, 2);
        push_sample(12'hFFF, 1'b0);
        push_sample(12'h001, 1'b0);
        wait_for_medians();

        // Random phases over several window sizes, both extremes first
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                h = MAX_HALF;
            end else if (p == 1) begin
                h = 0;
            end else begin
                h = $urandom_range(0, MAX_HALF);
            end
            write_config(ADDR_HALF_WIDTH, h);
            steady = (p == 2 || p == 3);
            run_signal_phase(PHASE_SAMPLES, $urandom_range(0, 3) != 0);
            wait_for_medians();
        end
        steady = 1'b0;

        if (sb.expected_medians.size() != 0) begin
            sb.report_mismatch($sformatf("%0d medians never arrived",
                                         sb.expected_medians.size()));
        end

        $display("Run covered %0d samples and %0d medians over %0d window settings",
                 samples_sent, sb.medians_checked, settings_used);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
